@@ rtl/bsdc_pkg.sv @@
// Shared types, constants and helpers for the click detector.
`timescale 1ns / 1ps
package bsdc_pkg;

   localparam int unsigned CountWidth  = 16;
   localparam int unsigned WindowWidth = 8;
   localparam int unsigned TdataWidth  = 8;

   localparam logic [WindowWidth-1:0] WindowReset = 8'd150;
   localparam logic [CountWidth-1:0]  CountMax    = 16'hFFFF;

   typedef enum logic [1:0] {
      EVENT_NONE   = 2'd0,
      EVENT_SINGLE = 2'd1,
      EVENT_DOUBLE = 2'd2
   } event_type;

   typedef struct packed {
      logic                  press_seen;
      logic                  press_counted;
      logic [1:0]            press_tally;
      logic [CountWidth-1:0] wait_ticks;
      logic [CountWidth-1:0] hold_ticks;
   } gesture_type;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      sat_inc = (v == CountMax) ? CountMax : v + 1'b1;
   endfunction

endpackage

@@ rtl/bsdc_core.sv @@
// Gesture state registers and the per-sample click classification logic.
`timescale 1ns / 1ps
module bsdc_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step_en,
   input  logic                                   key_level,
   input  logic [bsdc_pkg::WindowWidth-1:0]       click_window,
   output bsdc_pkg::event_type                    click_event
);
   import bsdc_pkg::*;

   gesture_type state_ff;
   gesture_type state_in;
   event_type   event_out;

   logic                  pressed;
   logic [CountWidth-1:0] hold_next;
   logic [CountWidth-1:0] wait_next;
   logic [CountWidth-1:0] win_ext;
   logic                  seen_next;
   logic                  counted_next;
   logic [1:0]            tally_next;

   assign pressed = ~key_level;
   assign win_ext = {{(CountWidth-WindowWidth){1'b0}}, click_window};

   always_comb begin
      hold_next    = pressed ? sat_inc(state_ff.hold_ticks) : '0;
      seen_next    = state_ff.press_seen | pressed;
      counted_next = state_ff.press_counted;
      tally_next   = state_ff.press_tally;
      wait_next    = sat_inc(state_ff.wait_ticks);

      state_in            = state_ff;
      state_in.hold_ticks = hold_next;
      event_out           = EVENT_NONE;

      if (!state_ff.press_counted && seen_next) begin
         tally_next   = state_ff.press_tally + 2'd1;
         counted_next = 1'b1;
      end

      if (!state_ff.press_counted && tally_next == 2'd2) begin
         // second press edge: report at once, skip release handling
         state_in.press_seen    = seen_next;
         state_in.press_counted = counted_next;
         state_in.press_tally   = 2'd0;
         state_in.wait_ticks    = '0;
         event_out              = EVENT_DOUBLE;
      end else begin
         state_in.press_seen    = pressed ? seen_next : 1'b0;
         state_in.press_counted = pressed ? counted_next : 1'b0;
         state_in.press_tally   = tally_next;
         if (tally_next == 2'd1) begin
            if (wait_next > win_ext && hold_next < win_ext) begin
               state_in.press_tally = 2'd0;
               state_in.wait_ticks  = '0;
               event_out            = EVENT_SINGLE;
            end else if (hold_next > win_ext) begin
               // held too long: drop the pending click
               state_in.press_tally = 2'd0;
               state_in.wait_ticks  = '0;
            end else begin
               state_in.wait_ticks  = wait_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   assign click_event = event_out;

endmodule

@@ rtl/button_single_double_click_detector.sv @@
// Top level: stream ports, input and result registers, window register.
// An accepted req item passes the input register, then the result register, to rsp.
// Throughput: one item per cycle unless rsp stalls; the state updates once per item.
// A stalled rsp side holds the result register; req keeps flowing while it is empty.
// Reset (synchronous, active high) clears the gesture state and the pipeline valids,
// and loads click_window with 150.
`timescale 1ns / 1ps
module button_single_double_click_detector (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bsdc_pkg::TdataWidth-1:0]   req_tdata,   // [0] key_level, [7:1] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bsdc_pkg::TdataWidth-1:0]   rsp_tdata,   // [1:0] click_event, [7:2] zero
   input  logic                              csr_wen,
   input  logic [bsdc_pkg::WindowWidth-1:0]  csr_wdata
);
   import bsdc_pkg::*;

   logic [WindowWidth-1:0] window_ff;
   logic                   in_valid_ff;
   logic                   in_level_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   event_type              out_event_ff;
   event_type              step_event;
   logic                   advance;
   logic                   step_en;

   assign advance    = ~out_valid_ff | rsp_tready;
   assign req_tready = ~in_valid_ff | advance;
   assign step_en    = in_valid_ff & advance;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WindowReset;
      end else if (csr_wen) begin
         window_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_level_ff <= req_tdata[0];
      end
      if (step_en) begin
         out_event_ff <= step_event;
      end
   end

   bsdc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .key_level    (in_level_ff),
      .click_window (window_ff),
      .click_event  (step_event)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(TdataWidth-2){1'b0}}, out_event_ff};

endmodule
